[design/bounded_deque_unit_defines.svh]
// Assertion helpers for the deque unit. They sample on clk and stay quiet while rst_n is low.
`ifndef BOUNDED_DEQUE_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bdq_pkg.sv]
package bdq_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

endpackage

[design/bdq_channels.sv]
interface bdq_req_if;
    logic                                valid;
    logic                                ready;
    logic [bdq_pkg::OP_W-1:0]            operation;
    logic signed [bdq_pkg::WORD_W-1:0]   push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface bdq_rsp_if #(parameter int CNT_W = 5);
    logic                                valid;
    logic                                ready;
    logic signed [bdq_pkg::WORD_W-1:0]   popped_value;
    logic [bdq_pkg::STATUS_W-1:0]        status;
    logic [CNT_W-1:0]                    fill_count;

    modport source (output valid, output popped_value, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input popped_value, input status, input fill_count,
                    output ready);
endinterface

[design/bdq_ring_store.sv]
module bdq_ring_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port: data shows in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/bounded_deque_unit.sv]
// Bounded double-ended queue of signed 32-bit words, DEPTH entries deep. Each request beat
// pushes at the front, pushes at the back, pops from the front or pops from the back, and
// yields exactly one response beat: the removed word (zero unless a pop succeeded), a status
// (ok, empty on pop, full on push) and the fill count after the request. Words live in a
// single-port-write, registered-read ring store addressed by a head index and the fill count,
// with slots wrapping modulo DEPTH (any DEPTH of 2 or more, not only powers of two). One request
// is in flight at a time. A push, or a pop that finds the deque empty, is answered from the
// idle state; a successful pop also passes the read state, since the word comes back from the
// store in the cycle after its address. A finished response sits in an output register, and
// the next request is taken in the same cycle that response is taken. No clearing pass follows
// reset: the store is only ever read at entries that hold a pushed word, so it starts at once.
`include "bounded_deque_unit_defines.svh"

module bounded_deque_unit #(
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Ring state
    logic [IDX_W-1:0]               head_reg,  head_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    bdq_pkg::state_t                state_reg, state_next;

    // Response register
    logic                           out_valid_reg,  out_valid_next;
    logic signed [bdq_pkg::WORD_W-1:0] popped_reg,  popped_next;
    bdq_pkg::status_t               status_reg,     status_next;
    logic [CNT_W-1:0]               fill_reg,       fill_next;

    // Store access
    logic                           wr_en;
    logic [IDX_W-1:0]               wr_addr;
    logic                           rd_en;
    logic [IDX_W-1:0]               rd_addr;
    logic [bdq_pkg::WORD_W-1:0]     rd_data;

    // Slot arithmetic
    logic [IDX_W-1:0]               head_dec;
    logic [IDX_W-1:0]               head_inc;
    logic [SUM_W-1:0]               back_sum;
    logic [SUM_W-1:0]               last_sum;
    logic [IDX_W-1:0]               back_slot;
    logic [IDX_W-1:0]               last_slot;
    logic                           is_full;
    logic                           is_empty;
    logic                           accept;

    bdq_ring_store #(
        .DEPTH (DEPTH),
        .WIDTH (bdq_pkg::WORD_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Take a new request only between items, and only when the response slot frees up.
    assign req.ready = (state_reg == bdq_pkg::ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Wrap the head one step either way without a modulo.
    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - IDX_W'(1);
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);

    // head + count stays below 2*DEPTH, so one compare and subtract wraps it.
    assign back_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign last_sum  = back_sum - SUM_W'(1);
    assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                   : IDX_W'(back_sum);
    assign last_slot = (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
                                                   : IDX_W'(last_sum);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        popped_next    = popped_reg;
        status_next    = status_reg;
        fill_next      = fill_reg;
        wr_en          = 1'b0;
        wr_addr        = back_slot;
        rd_en          = 1'b0;
        rd_addr        = head_reg;

        case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    status_next    = bdq_pkg::STATUS_OK;
                    popped_next    = '0;
                    out_valid_next = 1'b1;
                    case (bdq_pkg::op_t'(req.operation))
                        bdq_pkg::OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = bdq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = head_dec;
                                head_next  = head_dec;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        bdq_pkg::OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = bdq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = back_slot;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        bdq_pkg::OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = bdq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                // Launch the read; the word lands in the next cycle.
                                rd_en          = 1'b1;
                                rd_addr        = head_reg;
                                head_next      = head_inc;
                                count_next     = count_reg - CNT_W'(1);
                                out_valid_next = 1'b0;
                                state_next     = bdq_pkg::ST_READ;
                            end
                        end
                        bdq_pkg::OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = bdq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en          = 1'b1;
                                rd_addr        = last_slot;
                                count_next     = count_reg - CNT_W'(1);
                                out_valid_next = 1'b0;
                                state_next     = bdq_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            status_next = bdq_pkg::STATUS_OK;
                        end
                    endcase
                    fill_next = count_next;
                end
            end
            bdq_pkg::ST_READ:
            begin
                // Capture the popped word and present the response beat.
                popped_next    = $signed(rd_data);
                out_valid_next = 1'b1;
                state_next     = bdq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdq_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Response payload: hold while the beat waits, no reset needed.
    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
        fill_reg   <= fill_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = popped_reg;
    assign rsp.status       = status_reg;
    assign rsp.fill_count   = fill_reg;

    // The fill count never passes the capacity.
    `BDQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "fill count above DEPTH")
    // A pending read always completes into a response in the next cycle.
    `BDQ_ASSERT_NEXT(a_read_done, state_reg == bdq_pkg::ST_READ, (state_reg == bdq_pkg::ST_IDLE) && out_valid_reg, "pop read did not complete")
    // No new request is taken while a pop waits on the store.
    `BDQ_ASSERT_NOW(a_no_take_in_read, state_reg == bdq_pkg::ST_READ, !req.ready, "request taken during store read")
    // Every accepted request leaves either a pending read or a response beat.
    `BDQ_ASSERT_NEXT(a_accept_answered, accept, out_valid_reg || (state_reg == bdq_pkg::ST_READ), "request left without a response")

endmodule
